// ===== hw/rtl/indexed_min_heap_defines.svh =====
// Assertion macros shared by the indexed min-heap RTL.
`ifndef INDEXED_MIN_HEAP_DEFINES_SVH
`define INDEXED_MIN_HEAP_DEFINES_SVH
`ifndef SYNTHESIS
`define IHP_ASSERT_ALWAYS(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("indexed_min_heap assertion failed");
`define IHP_ASSERT_IMPLIES(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("indexed_min_heap assertion failed");
`define IHP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("indexed_min_heap assertion failed");
`else
`define IHP_ASSERT_ALWAYS(lbl, expr)
`define IHP_ASSERT_IMPLIES(lbl, ante, cons)
`define IHP_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ===== hw/rtl/ihp_pkg.sv =====
// Shared types and constants for the indexed min-heap.
`timescale 1ns / 1ps
package ihp_pkg;

  localparam int FUNC_W = 3;
  localparam int IDX_W  = 6;
  localparam int KEY_W  = 32;
  localparam int STAT_W = 2;
  localparam int CNT_W  = 7;

  typedef enum logic [FUNC_W-1:0] {
    FN_INSERT = 3'd0,
    FN_DELETE = 3'd1,
    FN_CHANGE = 3'd2,
    FN_DEC    = 3'd3,
    FN_INC    = 3'd4,
    FN_REMOVE = 3'd5,
    FN_QUERY  = 3'd6
  } func_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK       = 2'd0,
    ST_DUP_FULL = 2'd1,
    ST_EMPTY    = 2'd2,
    ST_ABSENT   = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_CLR,
    OP_ACCEPT,
    OP_LOOK,
    OP_FETCH,
    OP_UP_RD,
    OP_UP_CMP,
    OP_RL_RD,
    OP_RL_GET,
    OP_DN_RD,
    OP_DN_CMP,
    OP_CLR_POS,
    OP_TOP_RD,
    OP_TOP_GET,
    OP_LOAD
  } op_t;

  typedef struct packed {
    op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic              lk_err;
    logic              last_hit;
    logic              k_gt1;
    logic              up_swap;
    logic              c_le_cnt;
    logic              dn_swap;
    logic              clr_done;
  } dp_status_t;

endpackage

// ===== hw/rtl/ihp_ifs.sv =====
// Request and response channel interfaces.
`timescale 1ns / 1ps
interface ihp_req_if import ihp_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [FUNC_W-1:0] func;
  logic [IDX_W-1:0]  entry_index;
  logic [KEY_W-1:0]  key_value;

  modport source (output valid, func, entry_index, key_value, input ready);
  modport sink (input valid, func, entry_index, key_value, output ready);
endinterface

interface ihp_rsp_if import ihp_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [STAT_W-1:0] status;
  logic [IDX_W-1:0]  removed_index;
  logic              present;
  logic [KEY_W-1:0]  entry_key;
  logic [IDX_W-1:0]  top_index;
  logic [KEY_W-1:0]  min_key;
  logic [CNT_W-1:0]  entry_count;
  logic              is_empty;

  modport source (output valid, status, removed_index, present, entry_key, top_index,
                  min_key, entry_count, is_empty, input ready);
  modport sink (input valid, status, removed_index, present, entry_key, top_index,
                min_key, entry_count, is_empty, output ready);
endinterface

// ===== hw/rtl/ihp_ram.sv =====
// Generic single-write, single-read RAM with registered read.
`timescale 1ns / 1ps
module ihp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hw/rtl/ihp_dp.sv =====
// Heap datapath: slot and position memories, sift registers, result registers.
`timescale 1ns / 1ps
`include "indexed_min_heap_defines.svh"
module ihp_dp import ihp_pkg::*; #(
  parameter int MAX_ENTRIES = 64,
  parameter int KEY_WIDTH   = 32
) (
  input  logic              clk,
  input  logic              rst,
  input  dp_cmd_t           cmd,
  output dp_status_t        st,
  input  logic [FUNC_W-1:0] in_func,
  input  logic [IDX_W-1:0]  in_index,
  input  logic [KEY_W-1:0]  in_key,
  output logic [STAT_W-1:0] res_status,
  output logic [IDX_W-1:0]  res_removed_index,
  output logic              res_present,
  output logic [KEY_W-1:0]  res_entry_key,
  output logic [IDX_W-1:0]  res_top_index,
  output logic [KEY_W-1:0]  res_min_key,
  output logic [CNT_W-1:0]  res_entry_count,
  output logic              res_is_empty
);

  localparam int IW = $clog2(MAX_ENTRIES);
  localparam int SW = $clog2(MAX_ENTRIES + 1);
  localparam int HW = IW + KEY_WIDTH;

  typedef logic [KEY_WIDTH-1:0] key_t;
  typedef logic [SW-1:0]        slot_t;
  typedef logic [IW-1:0]        ent_t;

  // heap memory, two copies so a node's two children are read in the same cycle
  logic          heap_we;
  slot_t         heap_waddr;
  logic [HW-1:0] heap_wdata;
  slot_t         ha_raddr, hb_raddr;
  logic [HW-1:0] ha_rdata, hb_rdata;
  logic          pos_we;
  ent_t          pos_waddr, pos_raddr;
  slot_t         pos_wdata, pos_rdata;

  ent_t              a_e, b_e, pick_e;
  key_t              a_k, b_k, pick_k;
  logic              here, full, use_b, up_swap, dn_swap, k_gt1, c_le_cnt;
  logic [SW:0]       c_w, c1_w, cnt_w, pick_slot;
  status_t           lk_status;

  slot_t             count, k, s_save;
  ent_t              clr_cnt, cur_e, req_e, clr_e;
  key_t              cur_k, req_key, min_k;
  logic [FUNC_W-1:0] req_func;
  logic              req_inr, last_hit;
  status_t           r_status;
  ent_t              r_removed, min_e;
  logic              r_present;
  key_t              r_ekey;

  ihp_ram #(.WIDTH(HW), .DEPTH(MAX_ENTRIES + 1)) u_heap_a (
    .clk(clk), .we(heap_we), .waddr(heap_waddr), .wdata(heap_wdata),
    .raddr(ha_raddr), .rdata(ha_rdata)
  );
  ihp_ram #(.WIDTH(HW), .DEPTH(MAX_ENTRIES + 1)) u_heap_b (
    .clk(clk), .we(heap_we), .waddr(heap_waddr), .wdata(heap_wdata),
    .raddr(hb_raddr), .rdata(hb_rdata)
  );
  ihp_ram #(.WIDTH(SW), .DEPTH(MAX_ENTRIES)) u_pos (
    .clk(clk), .we(pos_we), .waddr(pos_waddr), .wdata(pos_wdata),
    .raddr(pos_raddr), .rdata(pos_rdata)
  );

  assign a_e = ha_rdata[HW-1:KEY_WIDTH];
  assign a_k = ha_rdata[KEY_WIDTH-1:0];
  assign b_e = hb_rdata[HW-1:KEY_WIDTH];
  assign b_k = hb_rdata[KEY_WIDTH-1:0];

  assign here     = req_inr && (pos_rdata != '0);
  assign full     = (count == slot_t'(MAX_ENTRIES));
  assign c_w      = {k, 1'b0};
  assign c1_w     = c_w + 1'b1;
  assign cnt_w    = {1'b0, count};
  assign c_le_cnt = (c_w <= cnt_w);
  assign k_gt1    = (k > slot_t'(1));
  // right child wins only on strictly smaller key, matching tie order
  assign use_b     = (c_w < cnt_w) && (a_k > b_k);
  assign pick_e    = use_b ? b_e : a_e;
  assign pick_k    = use_b ? b_k : a_k;
  assign pick_slot = use_b ? c1_w : c_w;
  assign up_swap   = (a_k > cur_k);
  assign dn_swap   = (cur_k > pick_k);

  always_comb begin
    lk_status = ST_OK;
    unique case (req_func)
      FN_INSERT: begin
        if (!req_inr) begin
          lk_status = ST_ABSENT;
        end else if (here || full) begin
          lk_status = ST_DUP_FULL;
        end
      end
      FN_DELETE: begin
        if (count == '0) begin
          lk_status = ST_EMPTY;
        end
      end
      FN_CHANGE, FN_DEC, FN_INC, FN_REMOVE: begin
        if (!here) begin
          lk_status = ST_ABSENT;
        end
      end
      FN_QUERY: begin
        if (!req_inr) begin
          lk_status = ST_ABSENT;
        end
      end
      default: ;
    endcase
  end

  assign st.func     = req_func;
  assign st.lk_err   = (lk_status != ST_OK);
  assign st.last_hit = last_hit;
  assign st.k_gt1    = k_gt1;
  assign st.up_swap  = up_swap;
  assign st.c_le_cnt = c_le_cnt;
  assign st.dn_swap  = dn_swap;
  assign st.clr_done = (clr_cnt == ent_t'(MAX_ENTRIES - 1));

  // memory ports
  always_comb begin
    heap_we    = 1'b0;
    heap_waddr = k;
    heap_wdata = {cur_e, cur_k};
    pos_we     = 1'b0;
    pos_waddr  = cur_e;
    pos_wdata  = k;
    ha_raddr   = '0;
    hb_raddr   = '0;
    pos_raddr  = ent_t'(in_index);
    unique case (cmd.op)
      OP_CLR: begin
        pos_we    = 1'b1;
        pos_waddr = clr_cnt;
        pos_wdata = '0;
      end
      OP_ACCEPT: begin
        ha_raddr = slot_t'(1);
        hb_raddr = count;
      end
      OP_LOOK: begin
        ha_raddr = pos_rdata;
      end
      OP_UP_RD: begin
        ha_raddr = k >> 1;
        if (!k_gt1) begin
          heap_we = 1'b1;
          pos_we  = 1'b1;
        end
      end
      OP_UP_CMP: begin
        heap_we = 1'b1;
        pos_we  = 1'b1;
        if (up_swap) begin
          heap_wdata = ha_rdata;
          pos_waddr  = a_e;
        end
      end
      OP_RL_RD: begin
        ha_raddr = s_save;
      end
      OP_DN_RD: begin
        ha_raddr = slot_t'(c_w);
        hb_raddr = slot_t'(c1_w);
        if (!c_le_cnt) begin
          heap_we = 1'b1;
          pos_we  = 1'b1;
        end
      end
      OP_DN_CMP: begin
        heap_we = 1'b1;
        pos_we  = 1'b1;
        if (dn_swap) begin
          heap_wdata = {pick_e, pick_k};
          pos_waddr  = pick_e;
        end
      end
      OP_CLR_POS: begin
        pos_we    = 1'b1;
        pos_waddr = clr_e;
        pos_wdata = '0;
      end
      OP_TOP_RD: begin
        ha_raddr = slot_t'(1);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count   <= '0;
      clr_cnt <= '0;
    end else begin
      unique case (cmd.op)
        OP_CLR: clr_cnt <= clr_cnt + 1'b1;
        OP_LOOK: begin
          if (lk_status == ST_OK) begin
            if (req_func == FN_INSERT) begin
              count <= count + 1'b1;
            end else if (req_func == FN_DELETE || req_func == FN_REMOVE) begin
              count <= count - 1'b1;
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (cmd.op)
      OP_ACCEPT: begin
        req_func  <= in_func;
        req_e     <= ent_t'(in_index);
        req_key   <= key_t'(in_key);
        req_inr   <= (int'(in_index) < MAX_ENTRIES);
        r_status  <= ST_OK;
        r_removed <= '0;
        r_present <= 1'b0;
        r_ekey    <= '0;
      end
      OP_LOOK: begin
        r_status <= lk_status;
        last_hit <= (pos_rdata == count);
        s_save   <= pos_rdata;
        clr_e    <= req_e;
        if (lk_status == ST_OK) begin
          unique case (req_func)
            FN_INSERT: begin
              cur_e <= req_e;
              cur_k <= req_key;
              k     <= count + 1'b1;
            end
            FN_DELETE: begin
              r_removed <= a_e;
              r_ekey    <= a_k;
              clr_e     <= a_e;
              cur_e     <= b_e;
              cur_k     <= b_k;
              k         <= slot_t'(1);
            end
            FN_CHANGE, FN_DEC, FN_INC: begin
              cur_e <= req_e;
              cur_k <= req_key;
              k     <= pos_rdata;
            end
            FN_REMOVE: begin
              // last entry fills the hole
              cur_e <= b_e;
              cur_k <= b_k;
              k     <= pos_rdata;
            end
            FN_QUERY: r_present <= here;
            default: ;
          endcase
        end
      end
      OP_FETCH: begin
        if (req_func == FN_REMOVE || r_present) begin
          r_ekey <= a_k;
        end
      end
      OP_UP_CMP: begin
        if (up_swap) begin
          k <= k >> 1;
        end
      end
      OP_RL_GET: begin
        cur_e <= a_e;
        cur_k <= a_k;
        k     <= s_save;
      end
      OP_DN_CMP: begin
        if (dn_swap) begin
          k <= slot_t'(pick_slot);
        end
      end
      OP_TOP_GET: begin
        if (count == '0) begin
          min_e <= '0;
          min_k <= '0;
        end else begin
          min_e <= a_e;
          min_k <= a_k;
        end
      end
      OP_LOAD: begin
        res_status        <= r_status;
        res_removed_index <= IDX_W'(r_removed);
        res_present       <= r_present;
        res_entry_key     <= KEY_W'(r_ekey);
        res_top_index     <= IDX_W'(min_e);
        res_min_key       <= KEY_W'(min_k);
        res_entry_count   <= CNT_W'(count);
        res_is_empty      <= (count == '0);
      end
      default: ;
    endcase
  end

  `IHP_ASSERT_ALWAYS(a_count_bound, count <= slot_t'(MAX_ENTRIES))
  `IHP_ASSERT_IMPLIES(a_up_has_parent, cmd.op == OP_UP_CMP, k > slot_t'(1))
  `IHP_ASSERT_NEXT(a_dn_moves_down, (cmd.op == OP_DN_CMP) && dn_swap, k > $past(k))

endmodule

// ===== hw/rtl/ihp_ctrl.sv =====
// Heap controller: sequences the reset clearing pass, lookup, sift-up, sift-down and result handoff.
`timescale 1ns / 1ps
`include "indexed_min_heap_defines.svh"
module ihp_ctrl import ihp_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  output logic       out_valid,
  input  logic       out_ready,
  input  dp_status_t st,
  output dp_cmd_t    cmd
);

  typedef enum logic [3:0] {
    S_CLR,
    S_IDLE,
    S_LOOK,
    S_FETCH,
    S_UP_RD,
    S_UP_CMP,
    S_RL_RD,
    S_RL_GET,
    S_DN_RD,
    S_DN_CMP,
    S_CLR_POS,
    S_TOP_RD,
    S_TOP_GET,
    S_FINISH
  } state_t;

  state_t state, state_next, up_exit, dn_exit;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    unique case (st.func)
      FN_CHANGE: up_exit = S_DN_RD;
      FN_REMOVE: up_exit = S_RL_RD;
      default:   up_exit = S_TOP_RD;
    endcase
    unique case (st.func)
      FN_DELETE, FN_REMOVE: dn_exit = S_CLR_POS;
      default:              dn_exit = S_TOP_RD;
    endcase
  end

  always_comb begin
    state_next = state;
    cmd.op     = OP_NONE;
    unique case (state)
      S_CLR: begin
        cmd.op = OP_CLR;
        if (st.clr_done) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.op     = OP_ACCEPT;
          state_next = S_LOOK;
        end
      end
      S_LOOK: begin
        cmd.op = OP_LOOK;
        if (st.lk_err) begin
          state_next = S_TOP_RD;
        end else begin
          unique case (st.func)
            FN_INSERT, FN_CHANGE, FN_DEC: state_next = S_UP_RD;
            FN_DELETE, FN_INC:            state_next = S_DN_RD;
            FN_REMOVE, FN_QUERY:          state_next = S_FETCH;
            default:                      state_next = S_TOP_RD;
          endcase
        end
      end
      S_FETCH: begin
        cmd.op = OP_FETCH;
        if (st.func != FN_REMOVE) begin
          state_next = S_TOP_RD;
        end else if (st.last_hit) begin
          state_next = S_CLR_POS;
        end else begin
          state_next = S_UP_RD;
        end
      end
      S_UP_RD: begin
        cmd.op     = OP_UP_RD;
        state_next = st.k_gt1 ? S_UP_CMP : up_exit;
      end
      S_UP_CMP: begin
        cmd.op     = OP_UP_CMP;
        state_next = st.up_swap ? S_UP_RD : up_exit;
      end
      S_RL_RD: begin
        cmd.op     = OP_RL_RD;
        state_next = S_RL_GET;
      end
      S_RL_GET: begin
        cmd.op     = OP_RL_GET;
        state_next = S_DN_RD;
      end
      S_DN_RD: begin
        cmd.op     = OP_DN_RD;
        state_next = st.c_le_cnt ? S_DN_CMP : dn_exit;
      end
      S_DN_CMP: begin
        cmd.op     = OP_DN_CMP;
        state_next = st.dn_swap ? S_DN_RD : dn_exit;
      end
      S_CLR_POS: begin
        cmd.op     = OP_CLR_POS;
        state_next = S_TOP_RD;
      end
      S_TOP_RD: begin
        cmd.op     = OP_TOP_RD;
        state_next = S_TOP_GET;
      end
      S_TOP_GET: begin
        cmd.op     = OP_TOP_GET;
        state_next = S_FINISH;
      end
      S_FINISH: begin
        if (!out_valid || out_ready) begin
          cmd.op     = OP_LOAD;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_CLR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLR;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.op == OP_LOAD) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  `IHP_ASSERT_NEXT(a_accept_look, in_valid && in_ready, state == S_LOOK)
  `IHP_ASSERT_NEXT(a_load_valid, cmd.op == OP_LOAD, out_valid)
  `IHP_ASSERT_NEXT(a_finish_waits, (state == S_FINISH) && out_valid && !out_ready,
                   state == S_FINISH)

endmodule

// ===== hw/rtl/indexed_min_heap.sv =====
// Indexed binary min-heap top level.
// Each request runs lookup (plus a key fetch for queries and removes), then any sift, which reads
// and then compares once per heap level walked, then the top-of-heap read and the result load.
// Throughput: one request at a time; the sift loop (one compare per RAM read) sets the rate.
// A new request is taken while the previous response waits in the output register.
// Reset: a clearing pass writes every position map entry, with no request taken until it completes.
`timescale 1ns / 1ps
module indexed_min_heap import ihp_pkg::*; #(
  parameter int MAX_ENTRIES = 64,
  parameter int KEY_WIDTH   = 32
) (
  input logic      clk,
  input logic      rst,
  ihp_req_if.sink  req,
  ihp_rsp_if.source rsp
);

  dp_cmd_t    cmd;
  dp_status_t st;
  logic       in_ready;
  logic       out_valid;

  ihp_ctrl u_ctrl (
    .clk(clk),
    .rst(rst),
    .in_valid(req.valid),
    .in_ready(in_ready),
    .out_valid(out_valid),
    .out_ready(rsp.ready),
    .st(st),
    .cmd(cmd)
  );

  ihp_dp #(.MAX_ENTRIES(MAX_ENTRIES), .KEY_WIDTH(KEY_WIDTH)) u_dp (
    .clk(clk),
    .rst(rst),
    .cmd(cmd),
    .st(st),
    .in_func(req.func),
    .in_index(req.entry_index),
    .in_key(req.key_value),
    .res_status(rsp.status),
    .res_removed_index(rsp.removed_index),
    .res_present(rsp.present),
    .res_entry_key(rsp.entry_key),
    .res_top_index(rsp.top_index),
    .res_min_key(rsp.min_key),
    .res_entry_count(rsp.entry_count),
    .res_is_empty(rsp.is_empty)
  );

  assign req.ready = in_ready;
  assign rsp.valid = out_valid;

endmodule

// ===== test/testbench.sv =====
// Self-checking testbench for the indexed min-heap: directed and random commands.
`timescale 1ns / 1ps
module testbench;
  import ihp_pkg::*;

  localparam int NUM_ENTRIES = 64;
  localparam int STALL_LIMIT = 20000;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [IDX_W-1:0]  entry_index;
    logic [KEY_W-1:0]  key_value;
  } heap_cmd_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [IDX_W-1:0]  removed_index;
    logic              present;
    logic [KEY_W-1:0]  entry_key;
    logic [IDX_W-1:0]  top_index;
    logic [KEY_W-1:0]  min_key;
    logic [CNT_W-1:0]  entry_count;
    logic              is_empty;
  } heap_rsp_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  ihp_req_if req ();
  ihp_rsp_if rsp ();

  indexed_min_heap dut (.clk(clk), .rst(rst), .req(req), .rsp(rsp));

  initial begin
    forever #2 clk = ~clk;
  end

  // predictor state
  logic [IDX_W-1:0] slot_entry [1:NUM_ENTRIES];
  logic [CNT_W-1:0] entry_slot [NUM_ENTRIES];
  logic [KEY_W-1:0] entry_key_mem [NUM_ENTRIES];
  int unsigned      heap_size;

  heap_cmd_t pending_cmds[$];
  heap_rsp_t expected_rsps[$];
  int        req_idle_pct;
  int        rsp_idle_pct;
  logic      hold_off;
  logic      stim_done;
  int        fail_count;
  int        stall_cycles;

  function automatic logic slot_gt(int a, int b);
    return entry_key_mem[slot_entry[a]] > entry_key_mem[slot_entry[b]];
  endfunction

  function automatic void swap_slot(int a, int b);
    logic [IDX_W-1:0] t;
    t = slot_entry[a];
    slot_entry[a] = slot_entry[b];
    slot_entry[b] = t;
    entry_slot[slot_entry[a]] = CNT_W'(a);
    entry_slot[slot_entry[b]] = CNT_W'(b);
  endfunction

  function automatic void bubble_up(int k);
    while (k > 1 && slot_gt(k / 2, k)) begin
      swap_slot(k, k / 2);
      k = k / 2;
    end
  endfunction

  function automatic void bubble_down(int k);
    int c;
    while (2 * k <= heap_size) begin
      c = 2 * k;
      if (c < heap_size && slot_gt(c, c + 1)) c++;
      if (!slot_gt(k, c)) break;
      swap_slot(k, c);
      k = c;
    end
  endfunction

  function automatic heap_rsp_t apply_heap_cmd(heap_cmd_t cmd);
    heap_rsp_t r;
    int e;
    int s;
    int last;
    logic here;
    e = int'(cmd.entry_index);
    here = entry_slot[e] != 0;
    r = '0;
    case (cmd.func)
      FN_INSERT: begin
        if (here || heap_size >= NUM_ENTRIES) r.status = ST_DUP_FULL;
        else begin
          heap_size++;
          entry_slot[e] = CNT_W'(heap_size);
          slot_entry[heap_size] = IDX_W'(e);
          entry_key_mem[e] = cmd.key_value;
          bubble_up(heap_size);
        end
      end
      FN_DELETE: begin
        if (heap_size == 0) r.status = ST_EMPTY;
        else begin
          s = int'(slot_entry[1]);
          swap_slot(1, heap_size);
          heap_size--;
          bubble_down(1);
          entry_slot[s] = '0;
          r.removed_index = IDX_W'(s);
          r.entry_key = entry_key_mem[s];
        end
      end
      FN_CHANGE, FN_DEC, FN_INC: begin
        if (!here) r.status = ST_ABSENT;
        else begin
          entry_key_mem[e] = cmd.key_value;
          if (cmd.func != FN_INC) bubble_up(entry_slot[e]);
          if (cmd.func != FN_DEC) bubble_down(entry_slot[e]);
        end
      end
      FN_REMOVE: begin
        if (!here) r.status = ST_ABSENT;
        else begin
          s = int'(entry_slot[e]);
          last = heap_size;
          swap_slot(s, last);
          heap_size--;
          if (s != last) begin
            bubble_up(s);
            bubble_down(s);
          end
          entry_slot[e] = '0;
          r.entry_key = entry_key_mem[e];
        end
      end
      FN_QUERY: begin
        if (here) begin
          r.present = 1'b1;
          r.entry_key = entry_key_mem[e];
        end
      end
      default: ;
    endcase
    if (heap_size > 0) begin
      r.top_index = slot_entry[1];
      r.min_key = entry_key_mem[slot_entry[1]];
    end
    r.entry_count = CNT_W'(heap_size);
    r.is_empty = heap_size == 0;
    return r;
  endfunction

  function automatic logic [KEY_W-1:0] rand_key();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      2: return $urandom_range(0, 7);
      default: return $urandom();
    endcase
  endfunction

  task automatic push_cmd(logic [FUNC_W-1:0] f, int idx, logic [KEY_W-1:0] k);
    heap_cmd_t c;
    c.func = f;
    c.entry_index = IDX_W'(idx);
    c.key_value = k;
    pending_cmds.push_back(c);
  endtask

  // driver
  always @(posedge clk) begin
    if (rst) begin
      req.valid <= 1'b0;
    end else if (!req.valid || req.ready) begin
      if (req.valid && req.ready)
        expected_rsps.push_back(apply_heap_cmd({req.func, req.entry_index, req.key_value}));
      if (pending_cmds.size() > 0 && !hold_off && $urandom_range(0, 99) >= req_idle_pct) begin
        heap_cmd_t c;
        c = pending_cmds.pop_front();
        req.valid <= 1'b1;
        req.func <= c.func;
        req.entry_index <= c.entry_index;
        req.key_value <= c.key_value;
      end else begin
        req.valid <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst) begin
      rsp.ready <= 1'b0;
      stall_cycles <= 0;
    end else begin
      if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) stall_cycles <= 0;
      else stall_cycles <= stall_cycles + 1;
      if (rsp.valid && rsp.ready) begin
        if (expected_rsps.size() == 0) begin
          $error("response with no request outstanding");
          fail_count++;
        end else begin
          heap_rsp_t x;
          x = expected_rsps.pop_front();
          if (rsp.status !== x.status) begin
            $error("status exp %0d got %0d", x.status, rsp.status); fail_count++;
          end
          if (rsp.removed_index !== x.removed_index) begin
            $error("removed_index exp %0d got %0d", x.removed_index, rsp.removed_index);
            fail_count++;
          end
          if (rsp.present !== x.present) begin
            $error("present exp %0d got %0d", x.present, rsp.present); fail_count++;
          end
          if (rsp.entry_key !== x.entry_key) begin
            $error("entry_key exp %0h got %0h", x.entry_key, rsp.entry_key); fail_count++;
          end
          if (rsp.top_index !== x.top_index) begin
            $error("top_index exp %0d got %0d", x.top_index, rsp.top_index); fail_count++;
          end
          if (rsp.min_key !== x.min_key) begin
            $error("min_key exp %0h got %0h", x.min_key, rsp.min_key); fail_count++;
          end
          if (rsp.entry_count !== x.entry_count) begin
            $error("entry_count exp %0d got %0d", x.entry_count, rsp.entry_count);
            fail_count++;
          end
          if (rsp.is_empty !== x.is_empty) begin
            $error("is_empty exp %0d got %0d", x.is_empty, rsp.is_empty); fail_count++;
          end
        end
      end
      rsp.ready <= $urandom_range(0, 99) >= rsp_idle_pct;
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (stall_cycles >= STALL_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic wait_drained();
    while (pending_cmds.size() > 0 || req.valid || expected_rsps.size() > 0)
      @(posedge clk);
  endtask

  initial begin
    int n;
    int live;
    req.valid = 1'b0;
    req.func = '0;
    req.entry_index = '0;
    req.key_value = '0;
    rsp.ready = 1'b0;
    for (int i = 0; i < NUM_ENTRIES; i++) entry_slot[i] = '0;
    heap_size = 0;
    fail_count = 0;
    hold_off = 1'b0;
    stim_done = 1'b0;
    req_idle_pct = 14;
    rsp_idle_pct = 57;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // directed: empty-heap errors, duplicates, ties, extremes, last-slot remove
    push_cmd(FN_DELETE, 0, 0);
    push_cmd(FN_QUERY, 63, 0);
    push_cmd(FN_CHANGE, 5, 1);
    push_cmd(FN_REMOVE, 5, 0);
    push_cmd(FN_INSERT, 63, '1);
    push_cmd(FN_INSERT, 63, 3);
    push_cmd(FN_INSERT, 0, 0);
    push_cmd(FN_INSERT, 21, 100);
    push_cmd(FN_INSERT, 42, 100);
    push_cmd(FN_INSERT, 7, 100);
    push_cmd(FN_QUERY, 21, 0);
    push_cmd(FN_DEC, 42, 200);
    push_cmd(FN_INC, 0, 50);
    push_cmd(FN_CHANGE, 63, 1);
    push_cmd(FN_REMOVE, 7, 0);
    push_cmd(3'd7, 9, 9);
    push_cmd(FN_DELETE, 0, 0);
    push_cmd(FN_INC, 21, 32'h8000_0000);
    push_cmd(FN_REMOVE, 63, 0);
    push_cmd(FN_DELETE, 0, 0);
    push_cmd(FN_DELETE, 0, 0);
    push_cmd(FN_DELETE, 0, 0);
    push_cmd(FN_QUERY, 42, 0);
    wait_drained();

    // fill to full and overflow
    for (int i = 0; i < NUM_ENTRIES; i++) push_cmd(FN_INSERT, i, rand_key());
    push_cmd(FN_INSERT, 17, 5);
    wait_drained();

    for (int phase = 0; phase < 3; phase++) begin
      if (phase == 1) begin
        req_idle_pct = 57;
        rsp_idle_pct = 14;
      end else if (phase == 2) begin
        req_idle_pct = 0;
        rsp_idle_pct = 0;
      end
      for (n = 0; n < 260; n++) begin
        live = $urandom_range(0, 99);
        if (live < 30) push_cmd(FN_INSERT, $urandom_range(0, 63), rand_key());
        else if (live < 45) push_cmd(FN_DELETE, $urandom_range(0, 63), rand_key());
        else if (live < 80)
          push_cmd(FUNC_W'($urandom_range(2, 4)), $urandom_range(0, 63), rand_key());
        else if (live < 88) push_cmd(FN_REMOVE, $urandom_range(0, 63), rand_key());
        else if (live < 97) push_cmd(FN_QUERY, $urandom_range(0, 63), rand_key());
        else push_cmd(3'd7, $urandom_range(0, 63), rand_key());
        if (n == 130) begin
          // hold off until the pipeline is empty
          while (pending_cmds.size() > 0 || req.valid) @(posedge clk);
          hold_off <= 1'b1;
          while (expected_rsps.size() > 0) @(posedge clk);
          hold_off <= 1'b0;
        end
      end
      wait_drained();
    end

    repeat (40) @(posedge clk);
    if (fail_count == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end
endmodule
